// ----- hdl/vtce_pkg.sv -----
// shared types, byte codes and the color digit table of the coordinate encoder
package vtce_pkg;

    localparam int QUEUE_DEPTH_DEF = 2;

    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 4;
    localparam int COLOR_W = 4;
    localparam int COORD_W = 10;
    localparam int BYTE_W = 7;

    localparam logic [CFG_IDX_W-1:0] CFG_COLOR_ENABLE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BACKGROUND   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FOREGROUND   = 2'd2;

    localparam logic [BYTE_W-1:0] BYTE_ESC = 7'h1B;
    localparam logic [BYTE_W-1:0] BYTE_GS  = 7'h1D;
    localparam logic [BYTE_W-1:0] BYTE_M   = 7'h4D;
    localparam logic [BYTE_W-1:0] BYTE_L   = 7'h4C;
    localparam logic [BYTE_W-1:0] DIGIT_BG = 7'h30;
    localparam logic [BYTE_W-1:0] DIGIT_FG = 7'h31;

    localparam logic [1:0] HIGH_TAG  = 2'b01;
    localparam logic [1:0] LOW_Y_TAG = 2'b11;
    localparam logic [1:0] LOW_X_TAG = 2'b10;

    localparam int STEP_ESC   = 0;
    localparam int STEP_M     = 1;
    localparam int STEP_L     = 2;
    localparam int STEP_DIGIT = 3;
    localparam int STEP_GS    = 4;
    localparam int STEP_HY    = 5;
    localparam int STEP_LY    = 6;
    localparam int STEP_HX    = 7;
    localparam int STEP_LX    = 8;
    localparam int NUM_STEPS  = 9;

    typedef struct packed {
        logic [NUM_STEPS-1:0] mask;
        logic [BYTE_W-1:0]    digit;
        logic [BYTE_W-1:0]    high_y;
        logic [BYTE_W-1:0]    low_y;
        logic [BYTE_W-1:0]    high_x;
        logic [BYTE_W-1:0]    low_x;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic empty;
    } t_queue_status;

    function automatic logic [BYTE_W-1:0] color_digit(input logic [COLOR_W-1:0] idx);
        logic [BYTE_W-1:0] d;
        case (idx)
            4'd0:    d = 7'h30;
            4'd1:    d = 7'h44;
            4'd2:    d = 7'h43;
            4'd3:    d = 7'h35;
            4'd4:    d = 7'h42;
            4'd5:    d = 7'h36;
            4'd6:    d = 7'h41;
            4'd7:    d = 7'h38;
            4'd8:    d = 7'h39;
            4'd9:    d = 7'h32;
            4'd10:   d = 7'h33;
            4'd11:   d = 7'h34;
            4'd12:   d = 7'h45;
            4'd13:   d = 7'h46;
            4'd14:   d = 7'h37;
            default: d = 7'h31;
        endcase
        return d;
    endfunction

endpackage

// ----- hdl/vtce_front.sv -----
// front end: accepts points, holds config and history, builds byte commands
module vtce_front (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [vtce_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [vtce_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                             i_in_valid,
    input  logic [vtce_pkg::COORD_W-1:0]     i_x_coord,
    input  logic [vtce_pkg::COORD_W-1:0]     i_y_coord,
    input  logic                             i_continue_vector,
    input  logic [vtce_pkg::COLOR_W-1:0]     i_color_index,
    input  vtce_pkg::t_queue_status          i_queue_status,
    output logic                             o_in_stall,
    output logic                             o_push,
    output vtce_pkg::t_cmd                   o_cmd
);
    import vtce_pkg::*;

    logic                r_color_enable;
    logic [COLOR_W-1:0]  r_background;
    logic [COLOR_W-1:0]  r_foreground;
    logic [BYTE_W-1:0]   r_prev_high_y, n_prev_high_y;
    logic [BYTE_W-1:0]   r_prev_low_y, n_prev_low_y;
    logic [BYTE_W-1:0]   r_prev_high_x, n_prev_high_x;
    logic [COLOR_W-1:0]  r_prev_color, n_prev_color;
    logic                r_prev_known, n_prev_known;

    logic send_color;
    logic hy_chg, ly_chg, hx_chg;
    logic accept;

    assign o_in_stall = i_queue_status.full;
    assign accept     = i_in_valid & ~i_queue_status.full;
    assign o_push     = accept;

    always_comb begin
        o_cmd.high_y = {HIGH_TAG, i_y_coord[9:5]};
        o_cmd.low_y  = {LOW_Y_TAG, i_y_coord[4:0]};
        o_cmd.high_x = {HIGH_TAG, i_x_coord[9:5]};
        o_cmd.low_x  = {LOW_X_TAG, i_x_coord[4:0]};
        if (i_color_index == r_background) begin
            o_cmd.digit = DIGIT_BG;
        end else if (i_color_index == r_foreground) begin
            o_cmd.digit = DIGIT_FG;
        end else begin
            o_cmd.digit = color_digit(i_color_index);
        end
        send_color = r_color_enable & (~r_prev_known | (i_color_index != r_prev_color));
        hy_chg = o_cmd.high_y != r_prev_high_y;
        ly_chg = o_cmd.low_y != r_prev_low_y;
        hx_chg = o_cmd.high_x != r_prev_high_x;
        o_cmd.mask             = '0;
        o_cmd.mask[STEP_ESC]   = send_color;
        o_cmd.mask[STEP_M]     = send_color;
        o_cmd.mask[STEP_L]     = send_color;
        o_cmd.mask[STEP_DIGIT] = send_color;
        o_cmd.mask[STEP_GS]    = ~i_continue_vector;
        o_cmd.mask[STEP_HY]    = hy_chg;
        o_cmd.mask[STEP_LY]    = hy_chg | ly_chg | hx_chg;
        o_cmd.mask[STEP_HX]    = hx_chg;
        o_cmd.mask[STEP_LX]    = 1'b1;
    end

    always_comb begin
        n_prev_high_y = r_prev_high_y;
        n_prev_low_y  = r_prev_low_y;
        n_prev_high_x = r_prev_high_x;
        n_prev_color  = r_prev_color;
        n_prev_known  = r_prev_known;
        if (accept) begin
            n_prev_high_y = o_cmd.high_y;
            n_prev_low_y  = o_cmd.low_y;
            n_prev_high_x = o_cmd.high_x;
            if (send_color) begin
                n_prev_color = i_color_index;
                n_prev_known = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_color_enable <= 1'b0;
            r_background   <= 4'd0;
            r_foreground   <= 4'd15;
            r_prev_high_y  <= '0;
            r_prev_low_y   <= '0;
            r_prev_high_x  <= '0;
            r_prev_color   <= '0;
            r_prev_known   <= 1'b0;
        end else begin
            r_prev_high_y <= n_prev_high_y;
            r_prev_low_y  <= n_prev_low_y;
            r_prev_high_x <= n_prev_high_x;
            r_prev_color  <= n_prev_color;
            r_prev_known  <= n_prev_known;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_COLOR_ENABLE: r_color_enable <= i_cfg_data[0];
                    CFG_BACKGROUND:   r_background   <= i_cfg_data[COLOR_W-1:0];
                    CFG_FOREGROUND:   r_foreground   <= i_cfg_data[COLOR_W-1:0];
                    default:          ;
                endcase
            end
        end
    end

endmodule

// ----- hdl/vtce_queue.sv -----
// command queue between the front end and the byte sequencer
module vtce_queue #(
    parameter int DEPTH = vtce_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_push,
    input  vtce_pkg::t_cmd           i_push_cmd,
    input  logic                     i_pop,
    output vtce_pkg::t_cmd           o_head_cmd,
    output vtce_pkg::t_queue_status  o_status
);
    import vtce_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    t_cmd             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;

    assign o_head_cmd     = r_mem[r_rd_ptr];
    assign o_status.full  = r_count == FULL_CNT;
    assign o_status.empty = r_count == '0;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_cmd;
        end
    end

endmodule

// ----- hdl/vtce_back.sv -----
// byte sequencer: walks the step mask of each command into the output register
module vtce_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  vtce_pkg::t_cmd                i_head_cmd,
    input  vtce_pkg::t_queue_status       i_queue_status,
    output logic                          o_pop,
    input  logic                          i_out_stall,
    output logic                          o_out_valid,
    output logic [vtce_pkg::BYTE_W-1:0]   o_out_byte,
    output logic                          o_last_byte
);
    import vtce_pkg::*;

    t_cmd                 r_cmd, n_cmd;
    logic [NUM_STEPS-1:0] r_mask, n_mask;
    logic                 r_out_valid, n_out_valid;
    logic [BYTE_W-1:0]    r_out_byte, n_out_byte;
    logic                 r_out_last, n_out_last;

    logic                 advance;
    logic [NUM_STEPS-1:0] lowest;
    logic [NUM_STEPS-1:0] rest;
    logic [BYTE_W-1:0]    step_byte [NUM_STEPS];
    logic [BYTE_W-1:0]    pick;

    assign advance = ~r_out_valid | ~i_out_stall;
    assign lowest  = r_mask & (~r_mask + 1'b1);
    assign rest    = r_mask & ~lowest;
    assign o_pop   = ~i_queue_status.empty & ((r_mask == '0) | (advance & (rest == '0)));

    always_comb begin
        step_byte[STEP_ESC]   = BYTE_ESC;
        step_byte[STEP_M]     = BYTE_M;
        step_byte[STEP_L]     = BYTE_L;
        step_byte[STEP_DIGIT] = r_cmd.digit;
        step_byte[STEP_GS]    = BYTE_GS;
        step_byte[STEP_HY]    = r_cmd.high_y;
        step_byte[STEP_LY]    = r_cmd.low_y;
        step_byte[STEP_HX]    = r_cmd.high_x;
        step_byte[STEP_LX]    = r_cmd.low_x;
        pick = '0;
        for (int i = 0; i < NUM_STEPS; i++) begin
            if (lowest[i]) begin
                pick = pick | step_byte[i];
            end
        end
    end

    always_comb begin
        n_cmd       = r_cmd;
        n_mask      = r_mask;
        n_out_valid = r_out_valid;
        n_out_byte  = r_out_byte;
        n_out_last  = r_out_last;
        if (advance) begin
            n_out_valid = r_mask != '0;
            n_out_byte  = pick;
            n_out_last  = lowest[STEP_LX];
            n_mask      = rest;
        end
        if (o_pop) begin
            n_cmd  = i_head_cmd;
            n_mask = i_head_cmd.mask;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_mask      <= n_mask;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd      <= n_cmd;
        r_out_byte <= n_out_byte;
        r_out_last <= n_out_last;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_byte  = r_out_byte;
    assign o_last_byte = r_out_last;

endmodule

// ----- hdl/vector_terminal_coordinate_encoder.sv -----
// top level of the vector terminal coordinate encoder
//
// input channel: one request per draw point (x, y, continue flag, color index),
// taken when i_in_valid is high and o_in_stall is low. output channel: one
// terminal byte per request, taken when o_out_valid is high and i_out_stall is
// low; o_last_byte marks the closing low-x byte of a point.
// a point produces 1 to 9 bytes: optional ESC M L digit when the line color
// changes, optional GS, optional high-y, low-y, high-x, then low-x.
// the byte sequencer emits one byte per cycle unless i_out_stall holds it;
// points waiting in the queue follow with no gap. an idle sequencer moves a
// queued point into its command register, then its first byte to the output register.
// the front end keeps taking points until the command queue is full.
// configuration writes (i_cfg_we, i_cfg_idx, i_cfg_data) take effect at the
// next edge and belong to idle periods.
// synchronous reset clears the queue, the output valid flag, the address and
// color history and restores the register defaults.
// while the receiver stalls, the output byte holds and the queue fills, then
// o_in_stall rises.
module vector_terminal_coordinate_encoder #(
    parameter int QUEUE_DEPTH = vtce_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [vtce_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [vtce_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic [vtce_pkg::COORD_W-1:0]     i_x_coord,
    input  logic [vtce_pkg::COORD_W-1:0]     i_y_coord,
    input  logic                             i_continue_vector,
    input  logic [vtce_pkg::COLOR_W-1:0]     i_color_index,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic [vtce_pkg::BYTE_W-1:0]      o_out_byte,
    output logic                             o_last_byte
);
    import vtce_pkg::*;

    t_cmd          push_cmd;
    t_cmd          head_cmd;
    t_queue_status queue_status;
    logic          push;
    logic          pop;

    vtce_front u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_idx         (i_cfg_idx),
        .i_cfg_data        (i_cfg_data),
        .i_in_valid        (i_in_valid),
        .i_x_coord         (i_x_coord),
        .i_y_coord         (i_y_coord),
        .i_continue_vector (i_continue_vector),
        .i_color_index     (i_color_index),
        .i_queue_status    (queue_status),
        .o_in_stall        (o_in_stall),
        .o_push            (push),
        .o_cmd             (push_cmd)
    );

    vtce_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_push_cmd (push_cmd),
        .i_pop      (pop),
        .o_head_cmd (head_cmd),
        .o_status   (queue_status)
    );

    vtce_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_head_cmd     (head_cmd),
        .i_queue_status (queue_status),
        .o_pop          (pop),
        .i_out_stall    (i_out_stall),
        .o_out_valid    (o_out_valid),
        .o_out_byte     (o_out_byte),
        .o_last_byte    (o_last_byte)
    );

endmodule

// ----- hdl/vtce_checker.sv -----
// port level checks of the coordinate encoder and their bind
module vtce_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            o_out_valid,
    input logic                            i_out_stall,
    input logic [vtce_pkg::BYTE_W-1:0]     o_out_byte,
    input logic                            o_last_byte
);
    import vtce_pkg::*;

    logic out_accept;
    assign out_accept = o_out_valid & ~i_out_stall;

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=>
            o_out_valid && $stable(o_out_byte) && $stable(o_last_byte))
        else $error("stalled output changed");

    a_last_is_low_x: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_last_byte |-> o_out_byte[6:5] == LOW_X_TAG)
        else $error("closing byte is not a low-x byte");

    a_escape_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_accept && o_out_byte == BYTE_ESC |=>
            o_out_valid && o_out_byte == BYTE_M && !o_last_byte)
        else $error("escape not followed by M");

endmodule

bind vector_terminal_coordinate_encoder vtce_checker u_vtce_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_byte  (o_out_byte),
    .o_last_byte (o_last_byte)
);

// ----- dv/tb_vector_terminal_coordinate_encoder.sv -----
// self-checking testbench for the vector terminal coordinate encoder
`timescale 1ns / 1ps

module tb_vector_terminal_coordinate_encoder;
    import vtce_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
    localparam logic [BYTE_W-1:0] HIGH_BASE  = 7'h20;
    localparam logic [BYTE_W-1:0] LOW_Y_BASE = 7'h60;
    localparam logic [BYTE_W-1:0] LOW_X_BASE = 7'h40;
    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_CYCLES = 300;

    typedef struct packed {
        logic [BYTE_W-1:0] code;
        logic              last;
    } t_term_byte;

    class term_stream_scoreboard;
        logic              color_on;
        logic [COLOR_W-1:0] bg_color;
        logic [COLOR_W-1:0] fg_color;
        logic [BYTE_W-1:0] sent_hy;
        logic [BYTE_W-1:0] sent_ly;
        logic [BYTE_W-1:0] sent_hx;
        logic [COLOR_W-1:0] sent_color;
        logic              color_sent;
        string             digit_chars;
        t_term_byte        pending_bytes[$];
        int                bad_count;

        function new();
            color_on    = 1'b0;
            bg_color    = 4'd0;
            fg_color    = 4'd15;
            sent_hy     = '0;
            sent_ly     = '0;
            sent_hx     = '0;
            sent_color  = '0;
            color_sent  = 1'b0;
            digit_chars = "0DC5B6A89234EF71";
            bad_count   = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_COLOR_ENABLE: color_on = data[0];
                CFG_BACKGROUND:   bg_color = data;
                CFG_FOREGROUND:   fg_color = data;
                default: ;
            endcase
        endfunction

        function void add(logic [BYTE_W-1:0] code, logic last);
            t_term_byte b;
            b.code = code;
            b.last = last;
            pending_bytes.push_back(b);
        endfunction

        function void take_point(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
                                 logic cont, logic [COLOR_W-1:0] color);
            logic [BYTE_W-1:0] hy, ly, hx, lx, digit;
            logic hy_new, ly_new, hx_new;
            if (color_on && (!color_sent || color != sent_color)) begin
                if (color == bg_color) begin
                    digit = DIGIT_BG;
                end else if (color == fg_color) begin
                    digit = DIGIT_FG;
                end else begin
                    digit = 7'(digit_chars[int'(color)]);
                end
                add(BYTE_ESC, 1'b0);
                add(BYTE_M, 1'b0);
                add(BYTE_L, 1'b0);
                add(digit, 1'b0);
                sent_color = color;
                color_sent = 1'b1;
            end
            hy = HIGH_BASE + 7'(y[9:5]);
            ly = LOW_Y_BASE + 7'(y[4:0]);
            hx = HIGH_BASE + 7'(x[9:5]);
            lx = LOW_X_BASE + 7'(x[4:0]);
            hy_new = hy != sent_hy;
            ly_new = ly != sent_ly;
            hx_new = hx != sent_hx;
            if (!cont) add(BYTE_GS, 1'b0);
            if (hy_new) add(hy, 1'b0);
            if (ly_new || hy_new || hx_new) add(ly, 1'b0);
            if (hx_new) add(hx, 1'b0);
            add(lx, 1'b1);
            sent_hy = hy;
            sent_ly = ly;
            sent_hx = hx;
        endfunction

        function void check_byte(logic [BYTE_W-1:0] code, logic last);
            t_term_byte want;
            if (pending_bytes.size() == 0) begin
                bad_count++;
                if (bad_count <= 10)
                    $display("%0t: unexpected byte %h last %b", $realtime, code, last);
            end else begin
                want = pending_bytes.pop_front();
                if (want.code !== code || want.last !== last) begin
                    bad_count++;
                    if (bad_count <= 10)
                        $display("%0t: byte mismatch: expected %h last %b, got %h last %b",
                                 $realtime, want.code, want.last, code, last);
                end
            end
        endfunction

        function int pending();
            return pending_bytes.size();
        endfunction
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_stall;
    logic [COORD_W-1:0]    i_x_coord = '0;
    logic [COORD_W-1:0]    i_y_coord = '0;
    logic                  i_continue_vector = 1'b0;
    logic [COLOR_W-1:0]    i_color_index = '0;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    logic [BYTE_W-1:0]     o_out_byte;
    logic                  o_last_byte;

    term_stream_scoreboard sb;
    int                    send_idle_pct = 0;
    int                    stall_pct = 0;
    logic                  hold_arm = 1'b0;
    logic                  hold_taken = 1'b0;
    int                    hold_left = 0;
    int                    cycle_count = 0;
    logic [COLOR_W-1:0]    pen_color = '0;

    vector_terminal_coordinate_encoder dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_idx         (i_cfg_idx),
        .i_cfg_data        (i_cfg_data),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_x_coord         (i_x_coord),
        .i_y_coord         (i_y_coord),
        .i_continue_vector (i_continue_vector),
        .i_color_index     (i_color_index),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_out_byte        (o_out_byte),
        .o_last_byte       (o_last_byte)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    // receiver: random stalls plus one long hold-off
    always @(posedge i_clk) begin
        if (hold_arm && !hold_taken) begin
            hold_taken  <= 1'b1;
            hold_left   <= HOLD_CYCLES;
            i_out_stall <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left   <= hold_left - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && !o_in_stall)
            sb.take_point(i_x_coord, i_y_coord, i_continue_vector, i_color_index);
        if (i_rst_n && o_out_valid && !i_out_stall)
            sb.check_byte(o_out_byte, o_last_byte);
    end

    task automatic send_point(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y,
                              input logic cont, input logic [COLOR_W-1:0] color);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid        <= 1'b1;
        i_x_coord         <= x;
        i_y_coord         <= y;
        i_continue_vector <= cont;
        i_color_index     <= color;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    task automatic write_one(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        sb.write_reg(idx, data);
    endtask

    task automatic set_colors(input logic [CFG_DATA_W-1:0] en_data,
                              input logic [COLOR_W-1:0] bg, input logic [COLOR_W-1:0] fg,
                              input bit poke_unused);
        write_one(CFG_COLOR_ENABLE, en_data);
        write_one(CFG_BACKGROUND, bg);
        write_one(CFG_FOREGROUND, fg);
        if (poke_unused) write_one(CFG_UNUSED, 4'($urandom));
        i_cfg_we <= 1'b0;
    endtask

    // mostly connected strokes with small steps and 32-unit jumps, some stray points
    task automatic random_stroke(inout int sent);
        logic [COORD_W-1:0] x, y;
        int len;
        if ($urandom_range(0, 99) < 20) begin
            send_point(10'($urandom), 10'($urandom), 1'($urandom), 4'($urandom));
            sent++;
        end else begin
            len = $urandom_range(1, 8);
            x = 10'($urandom);
            y = 10'($urandom);
            if ($urandom_range(0, 3) == 0) pen_color = 4'($urandom);
            for (int i = 0; i < len; i++) begin
                if (i != 0 && $urandom_range(0, 9) == 0) pen_color = 4'($urandom);
                send_point(x, y, i != 0, pen_color);
                sent++;
                case ($urandom_range(0, 4))
                    0: x = x + 10'($urandom_range(0, 6)) - 10'd3;
                    1: y = y + 10'($urandom_range(0, 6)) - 10'd3;
                    2: begin
                        x = x + 10'($urandom_range(0, 6)) - 10'd3;
                        y = y + 10'($urandom_range(0, 6)) - 10'd3;
                    end
                    3: x = x + 10'd32;
                    default: y = y - 10'd32;
                endcase
            end
        end
    endtask

    initial begin
        int sent;
        sb = new();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // address suppression with color output off
        send_point(10'd0, 10'd0, 1'b0, 4'd0);
        send_point(10'd0, 10'd0, 1'b1, 4'd0);
        send_point(10'd1023, 10'd1023, 1'b1, 4'd15);
        send_point(10'd1022, 10'd1023, 1'b1, 4'd15);
        send_point(10'd1022, 10'd992, 1'b1, 4'd15);
        send_point(10'd990, 10'd992, 1'b1, 4'd15);
        send_point(10'd990, 10'd960, 1'b0, 4'd15);
        drain();

        // color escapes, first color after reset included
        set_colors(4'hF, 4'd0, 4'd15, 1'b0);
        send_point(10'd512, 10'd31, 1'b0, 4'd0);
        send_point(10'd513, 10'd32, 1'b1, 4'd0);
        send_point(10'd31, 10'd32, 1'b1, 4'd15);
        send_point(10'd32, 10'd511, 1'b0, 4'd5);
        send_point(10'd341, 10'd682, 1'b1, 4'd9);
        drain();

        // background wins when both colors match; unused index ignored
        set_colors(4'h1, 4'd7, 4'd7, 1'b1);
        send_point(10'd682, 10'd341, 1'b0, 4'd7);
        send_point(10'd100, 10'd200, 1'b1, 4'd3);
        drain();

        // color off keeps the last color sent
        set_colors(4'hE, 4'd7, 4'd7, 1'b0);
        send_point(10'd100, 10'd200, 1'b0, 4'd12);
        drain();
        set_colors(4'h1, 4'd7, 4'd7, 1'b0);
        send_point(10'd101, 10'd200, 1'b1, 4'd3);
        send_point(10'd102, 10'd201, 1'b1, 4'd12);
        drain();

        set_colors(4'h1, 4'd15, 4'd0, 1'b0);
        send_point(10'd700, 10'd900, 1'b0, 4'd0);
        send_point(10'd700, 10'd900, 1'b1, 4'd15);
        drain();

        for (int p = 0; p < 5; p++) begin
            case (p)
                0: begin
                    set_colors({3'($urandom), 1'b1}, 4'd0, 4'd15, 1'b0);
                    send_idle_pct = 0;
                    stall_pct <= 0;
                end
                1: begin
                    set_colors({3'($urandom), 1'b1}, 4'd15, 4'd0, 1'b1);
                    send_idle_pct = 88;
                    stall_pct <= 0;
                end
                2: begin
                    set_colors({3'($urandom), 1'b0}, 4'($urandom), 4'($urandom), 1'b0);
                    send_idle_pct = 0;
                    stall_pct <= 88;
                end
                3: begin
                    set_colors({3'($urandom), 1'b1}, 4'($urandom), 4'($urandom), 1'b1);
                    send_idle_pct = 19;
                    stall_pct <= 19;
                end
                default: begin
                    set_colors({3'($urandom), 1'b1}, 4'($urandom), 4'($urandom), 1'b0);
                    send_idle_pct = 0;
                    stall_pct <= 0;
                    hold_arm <= 1'b1;
                end
            endcase
            sent = 0;
            while (sent < 36) random_stroke(sent);
            drain();
        end

        repeat (10) @(posedge i_clk);
        if (sb.bad_count == 0 && sb.pending() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

// ----- vector_terminal_coordinate_encoder.f -----
hdl/vtce_pkg.sv
hdl/vtce_front.sv
hdl/vtce_queue.sv
hdl/vtce_back.sv
hdl/vector_terminal_coordinate_encoder.sv
hdl/vtce_checker.sv
dv/tb_vector_terminal_coordinate_encoder.sv
